### src/tars_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tars_pkg
// Shared types and constants for the torus adaptive route select block.
// ----------------------------------------------------------------------------
package tars_pkg;

    // Router numbers are 8 bits wide, so the grid holds at most 256 routers.
    localparam int NODE_W   = 8;
    localparam int BUF_W    = 8;
    localparam int PAY_W    = 16;
    localparam int W_W      = 5;
    localparam int THR_W    = 15;
    localparam int REM_W    = 4;
    localparam int OFF_W    = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 15;
    localparam int PORT_W   = 3;

    localparam logic [W_W-1:0]   GRID_W_RESET = W_W'(4);
    localparam logic [W_W-1:0]   GRID_W_MAX   = W_W'(16);
    localparam logic [W_W-1:0]   GRID_W_MIN   = W_W'(1);
    localparam logic [THR_W-1:0] SPIKE_RESET  = THR_W'(127);
    localparam logic [BUF_W-1:0] BUF_LIMIT    = BUF_W'(5);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_THR  = 1'b1;

    // Output port codes.
    typedef enum logic [PORT_W-1:0] {
        PORT_NORTH = 3'd0,
        PORT_SOUTH = 3'd1,
        PORT_EAST  = 3'd2,
        PORT_WEST  = 3'd3,
        PORT_LOCAL = 3'd4,
        PORT_HOLD  = 3'd5
    } t_port;

    typedef struct packed {
        logic north;
        logic south;
        logic east;
        logic west;
    } t_flags;

    // Header fields that ride along the divider chain untouched.
    typedef struct packed {
        logic [BUF_W-1:0] buffer_count;
        logic [PAY_W-1:0] payload_value;
        t_flags           flags;
        logic             arrive;
    } t_side;

    // Data held in each divider cell.
    typedef struct packed {
        logic [NODE_W-1:0] num_d;
        logic [NODE_W-1:0] num_c;
        logic [NODE_W-1:0] quo_d;
        logic [NODE_W-1:0] quo_c;
        logic [REM_W-1:0]  rem_d;
        logic [REM_W-1:0]  rem_c;
        t_side             side;
    } t_cell_data;

    // Short and long wrap offsets of both axes, two's complement.
    typedef struct packed {
        logic [OFF_W-1:0] sx;
        logic [OFF_W-1:0] lx;
        logic [OFF_W-1:0] sy;
        logic [OFF_W-1:0] ly;
        logic             go_long;
        t_flags           flags;
        logic             arrive;
    } t_offs;

endpackage
`default_nettype wire

### src/tars_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tars_req_if
// Header channel: valid, ready and the packet header fields.
// ----------------------------------------------------------------------------
interface tars_req_if;
    import tars_pkg::*;

    logic              valid;
    logic              ready;
    logic [BUF_W-1:0]  buffer_count;
    logic [NODE_W-1:0] dest_router;
    logic [NODE_W-1:0] current_router;
    logic [PAY_W-1:0]  payload_value;
    logic              north_full;
    logic              south_full;
    logic              east_full;
    logic              west_full;

    modport source (
        output valid, buffer_count, dest_router, current_router, payload_value,
               north_full, south_full, east_full, west_full,
        input  ready
    );

    modport sink (
        input  valid, buffer_count, dest_router, current_router, payload_value,
               north_full, south_full, east_full, west_full,
        output ready
    );
endinterface
`default_nettype wire

### src/tars_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tars_rsp_if
// Result channel: valid, ready and the selected output port.
// ----------------------------------------------------------------------------
interface tars_rsp_if;
    import tars_pkg::*;

    logic              valid;
    logic              ready;
    logic [PORT_W-1:0] out_port;

    modport source (
        output valid, out_port,
        input  ready
    );

    modport sink (
        input  valid, out_port,
        output ready
    );
endinterface
`default_nettype wire

### src/tars_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tars_div_cell
// One restoring division step for both router numbers: consumes the top
// numerator bit, develops one quotient bit and hands the result onward.
// ----------------------------------------------------------------------------
module tars_div_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [tars_pkg::W_W-1:0] i_w,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire tars_pkg::t_cell_data i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output tars_pkg::t_cell_data      o_data
);
    import tars_pkg::*;

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;

    // Trial subtraction of the divisor from the shifted remainder.
    function automatic logic [REM_W:0] div_step(
        input logic [REM_W-1:0] rem,
        input logic             bit_in,
        input logic [W_W-1:0]   w
    );
        logic [REM_W:0] t;
        logic [REM_W:0] diff;
        t    = {rem, bit_in};
        diff = t - w;
        if (t >= w) begin
            div_step = {1'b1, diff[REM_W-1:0]};
        end else begin
            div_step = {1'b0, t[REM_W-1:0]};
        end
    endfunction

    // Next cell contents.
    always_comb begin
        logic [REM_W:0] sd;
        logic [REM_W:0] sc;
        sd = div_step(i_data.rem_d, i_data.num_d[NODE_W-1], i_w);
        sc = div_step(i_data.rem_c, i_data.num_c[NODE_W-1], i_w);
        n_data       = i_data;
        n_data.num_d = {i_data.num_d[NODE_W-2:0], 1'b0};
        n_data.num_c = {i_data.num_c[NODE_W-2:0], 1'b0};
        n_data.quo_d = {i_data.quo_d[NODE_W-2:0], sd[REM_W]};
        n_data.quo_c = {i_data.quo_c[NODE_W-2:0], sc[REM_W]};
        n_data.rem_d = sd[REM_W-1:0];
        n_data.rem_c = sc[REM_W-1:0];
    end

    assign o_ready = !r_valid || i_ready;

    // Stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage data, loaded on each transfer in.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

### src/tars_offset.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tars_offset
// Forms the short and long wrap offsets of each axis from the row and column
// of both routers, and decides whether the packet may take the long way.
// ----------------------------------------------------------------------------
module tars_offset (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [tars_pkg::W_W-1:0]   i_w,
    input  wire logic [tars_pkg::THR_W-1:0] i_thr,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire tars_pkg::t_cell_data     i_data,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output tars_pkg::t_offs               o_offs
);
    import tars_pkg::*;

    logic  r_valid;
    t_offs r_offs;
    t_offs n_offs;

    // Short offset in the upper half, long offset in the lower half.
    function automatic logic [2*OFF_W-1:0] axis_offsets(
        input logic [OFF_W-1:0] d,
        input logic [W_W-1:0]   w
    );
        logic [OFF_W-1:0] a;
        logic [OFF_W-1:0] wa;
        logic [OFF_W-1:0] far;
        logic [OFF_W-1:0] half;
        a    = d[OFF_W-1] ? (~d + OFF_W'(1)) : d;
        half = OFF_W'(w >> 1);
        wa   = OFF_W'(w) - a;
        far  = d[OFF_W-1] ? wa : (~wa + OFF_W'(1));
        if (d == '0) begin
            axis_offsets = {{OFF_W{1'b0}}, OFF_W'(w)};
        end else if (a > half) begin
            axis_offsets = {far, d};
        end else begin
            axis_offsets = {d, far};
        end
    endfunction

    // Axis offsets and the long-route condition.
    always_comb begin
        logic [OFF_W-1:0]   dx;
        logic [OFF_W-1:0]   dy;
        logic [2*OFF_W-1:0] ax;
        logic [2*OFF_W-1:0] ay;
        logic               none_full;
        dx = OFF_W'(i_data.rem_d) - OFF_W'(i_data.rem_c);
        dy = OFF_W'(i_data.quo_d) - OFF_W'(i_data.quo_c);
        ax = axis_offsets(dx, i_w);
        ay = axis_offsets(dy, i_w);
        none_full = !(i_data.side.flags.north || i_data.side.flags.south
                      || i_data.side.flags.east || i_data.side.flags.west);
        n_offs.sx      = ax[2*OFF_W-1:OFF_W];
        n_offs.lx      = ax[OFF_W-1:0];
        n_offs.sy      = ay[2*OFF_W-1:OFF_W];
        n_offs.ly      = ay[OFF_W-1:0];
        n_offs.go_long = (i_data.side.payload_value > {1'b0, i_thr} + {1'b0, i_thr})
                         && (i_data.side.buffer_count < BUF_LIMIT) && none_full;
        n_offs.flags   = i_data.side.flags;
        n_offs.arrive  = i_data.side.arrive;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_offs <= n_offs;
        end
    end

    assign o_valid = r_valid;
    assign o_offs  = r_offs;
endmodule
`default_nettype wire

### src/tars_decide.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tars_decide
// Picks the axis from the chosen offsets and the neighbor-full flags and
// holds the resulting port in the output register.
// ----------------------------------------------------------------------------
module tars_decide (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire tars_pkg::t_offs i_offs,
    output logic                o_valid,
    input  wire logic           i_ready,
    output tars_pkg::t_port     o_port
);
    import tars_pkg::*;

    logic  r_valid;
    t_port r_port;
    t_port n_port;

    // Axis choice following the long-route, zero-offset and flag rules.
    always_comb begin
        logic signed [OFF_W-1:0] cx;
        logic signed [OFF_W-1:0] cy;
        logic rules;
        logic vert;
        logic horz;
        logic hold;
        logic hpos;
        logic hneg;
        logic vpos;
        logic vneg;
        logic none_full;
        logic all_full;
        cx    = $signed(i_offs.go_long ? i_offs.lx : i_offs.sx);
        cy    = $signed(i_offs.go_long ? i_offs.ly : i_offs.sy);
        rules = 1'b1;
        vert  = 1'b0;
        horz  = 1'b0;
        hold  = 1'b0;
        hpos  = cx > 0;
        hneg  = cx < 0;
        vpos  = cy > 0;
        vneg  = cy < 0;
        none_full = !(i_offs.flags.north || i_offs.flags.south
                      || i_offs.flags.east || i_offs.flags.west);
        all_full  = i_offs.flags.north && i_offs.flags.south
                    && i_offs.flags.east && i_offs.flags.west;

        // Long, untied: larger cx goes vertical, larger cy horizontal.
        if (i_offs.go_long) begin
            if (cx > cy) begin
                vert  = 1'b1;
                rules = 1'b0;
            end else if (cy > cx) begin
                horz  = 1'b1;
                rules = 1'b0;
            end
        end

        if (cx == 0) begin
            vert = 1'b1;
        end else if (cy == 0) begin
            horz = 1'b1;
        end else if (rules) begin
            if (none_full) begin
                vert = 1'b1;
            end else if (all_full) begin
                hold = 1'b1;
            end else if ((hpos && i_offs.flags.east) || (hneg && i_offs.flags.west)) begin
                vert = 1'b1;
            end else if ((vpos && i_offs.flags.north) || (vneg && i_offs.flags.south)) begin
                horz = 1'b1;
            end else begin
                vert = 1'b1;
            end
        end

        if (i_offs.arrive) begin
            n_port = PORT_LOCAL;
        end else if (hold) begin
            n_port = PORT_HOLD;
        end else if (horz) begin
            n_port = hpos ? PORT_EAST : PORT_WEST;
        end else begin
            n_port = vpos ? PORT_SOUTH : PORT_NORTH;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_port <= n_port;
        end
    end

    assign o_valid = r_valid;
    assign o_port  = r_port;
endmodule
`default_nettype wire

### src/torus_adaptive_route_select_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 8 divider cells, one offset stage, one decision stage that is also
// the output register; the header is registered through each in turn.
// Throughput: one header per cycle unless o_rsp.ready stalls the chain; the row
// and column division runs one quotient bit per cell down the divider chain.
// Reset clears all stage valids and loads grid width 4 and threshold 127.
// ----------------------------------------------------------------------------
// torus_adaptive_route_select_top
// Adaptive minimal route selection for one router of a square 2D torus.
// ----------------------------------------------------------------------------
module torus_adaptive_route_select_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tars_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tars_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tars_req_if.sink                              i_req,
    tars_rsp_if.source                            o_rsp
);
    import tars_pkg::*;

    localparam int CELLS = NODE_W;

    logic [W_W-1:0]   r_grid_width;
    logic [THR_W-1:0] r_spike_thr;
    logic [W_W-1:0]   w_eff;

    logic       cell_valid [CELLS+1];
    logic       cell_ready [CELLS+1];
    t_cell_data cell_data  [CELLS+1];

    logic  offs_valid;
    logic  offs_ready;
    t_offs offs;
    t_port port;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= GRID_W_RESET;
            r_spike_thr  <= SPIKE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_WIDTH: r_grid_width <= i_cfg_data[W_W-1:0];
                CFG_SPIKE_THR:  r_spike_thr  <= i_cfg_data[THR_W-1:0];
                default:        r_spike_thr  <= r_spike_thr;
            endcase
        end
    end

    // Width clamped to the supported range.
    always_comb begin
        if (r_grid_width == '0) begin
            w_eff = GRID_W_MIN;
        end else if (r_grid_width > GRID_W_MAX) begin
            w_eff = GRID_W_MAX;
        end else begin
            w_eff = r_grid_width;
        end
    end

    // Header entering the divider chain.
    always_comb begin
        cell_data[0].num_d  = i_req.dest_router;
        cell_data[0].num_c  = i_req.current_router;
        cell_data[0].quo_d  = '0;
        cell_data[0].quo_c  = '0;
        cell_data[0].rem_d  = '0;
        cell_data[0].rem_c  = '0;
        cell_data[0].side.buffer_count  = i_req.buffer_count;
        cell_data[0].side.payload_value = i_req.payload_value;
        cell_data[0].side.flags.north   = i_req.north_full;
        cell_data[0].side.flags.south   = i_req.south_full;
        cell_data[0].side.flags.east    = i_req.east_full;
        cell_data[0].side.flags.west    = i_req.west_full;
        cell_data[0].side.arrive        = (i_req.dest_router == i_req.current_router);
    end

    assign cell_valid[0] = i_req.valid;
    assign i_req.ready   = cell_ready[0];

    // Divider chain: one quotient bit per cell.
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        tars_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_w     (w_eff),
            .i_valid (cell_valid[g]),
            .o_ready (cell_ready[g]),
            .i_data  (cell_data[g]),
            .o_valid (cell_valid[g+1]),
            .i_ready (cell_ready[g+1]),
            .o_data  (cell_data[g+1])
        );
    end

    tars_offset u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_w     (w_eff),
        .i_thr   (r_spike_thr),
        .i_valid (cell_valid[CELLS]),
        .o_ready (cell_ready[CELLS]),
        .i_data  (cell_data[CELLS]),
        .o_valid (offs_valid),
        .i_ready (offs_ready),
        .o_offs  (offs)
    );

    tars_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (offs_valid),
        .o_ready (offs_ready),
        .i_offs  (offs),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_port  (port)
    );

    assign o_rsp.out_port = port;
endmodule
`default_nettype wire
